@@ hw/rtl/ncc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_pkg
// Types, constants and corner tables shared by the circle control point block.
// ----------------------------------------------------------------------------
package ncc_pkg;

	localparam logic [31:0] HELPER_LIMIT = 32'd966367642;
	localparam logic [15:0] WEIGHT_ONE   = 16'd32768;
	localparam logic [15:0] WEIGHT_DIAG  = 16'd23170;
	localparam logic [3:0]  LAST_POINT   = 4'd8;
	localparam logic [3:0]  PT_DEPTH     = 4'd4;

	typedef struct packed {
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] center_z;
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] normal_z;
		logic        [30:0] radius;
	} item_t;

	typedef struct packed {
		logic        [3:0]  point_index;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic        [15:0] weight;
		logic               bad_normal;
		logic               last;
	} point_t;

	typedef struct packed {
		logic [2:0][31:0] ctr;
		logic [30:0]      rad;
		logic [2:0][31:0] u;
		logic [2:0][32:0] v;
		logic             bad;
	} frame_t;

	typedef enum logic [2:0] {
		F_IDLE, F_SHIFT, F_SQ, F_SQRT, F_DIV, F_NEXT, F_CROSS, F_PUSH
	} front_st_t;

	function automatic logic signed [1:0] corner_px(input logic [3:0] k);
		logic signed [1:0] r;
		unique case (k)
			4'd0, 4'd1, 4'd7, 4'd8: r = 2'sd1;
			4'd3, 4'd4, 4'd5:       r = -2'sd1;
			default:                r = 2'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [1:0] corner_py(input logic [3:0] k);
		logic signed [1:0] r;
		unique case (k)
			4'd1, 4'd2, 4'd3: r = 2'sd1;
			4'd5, 4'd6, 4'd7: r = -2'sd1;
			default:          r = 2'sd0;
		endcase
		return r;
	endfunction

	// operand indexes for v = n x u, two products per component
	function automatic logic [1:0] cross_n_idx(input logic [2:0] s);
		logic [1:0] r;
		unique case (s)
			3'd0, 3'd5: r = 2'd1;
			3'd1, 3'd2: r = 2'd2;
			default:    r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] cross_u_idx(input logic [2:0] s);
		logic [1:0] r;
		unique case (s)
			3'd0, 3'd3: r = 2'd2;
			3'd1, 3'd4: r = 2'd1;
			default:    r = 2'd0;
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/nurbs_circle_control_points.sv @@
`timescale 1ns / 1ps
// Input beats are paced by the frame sequencer (normalising shifts, 32-step square roots and
// divider lanes); a one-entry buffer takes the next beat while a frame is being formed.
// Nine point beats follow each frame, one per cycle when pop is held.
// Reset: arst_n clears all queues and the sequencer; payload is not cleared.
// ----------------------------------------------------------------------------
// nurbs_circle_control_points
// Nine-point rational quadratic circle: frame sequencer, frame queue and
// point pipeline with a result queue.
// ----------------------------------------------------------------------------
module nurbs_circle_control_points (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  ncc_pkg::item_t  item,
	output logic            empty,
	input  logic            pop,
	output ncc_pkg::point_t point
);

	logic            fq_push, fq_full, fq_pop, fq_vld;
	ncc_pkg::frame_t fq_din, fq_dout;

	ncc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.fq_push (fq_push),
		.fq_din  (fq_din),
		.fq_full (fq_full)
	);

	ncc_frame_q u_frame_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (fq_push),
		.din    (fq_din),
		.full   (fq_full),
		.rd     (fq_pop),
		.dout   (fq_dout),
		.vld    (fq_vld)
	);

	ncc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.frm     (fq_dout),
		.frm_vld (fq_vld),
		.frm_pop (fq_pop),
		.point   (point),
		.empty   (empty),
		.pop     (pop)
	);

	a_fq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fq_push |-> !fq_full) else $error("frame written into full queue");

	a_fq_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		fq_pop |-> fq_vld) else $error("frame released from empty queue");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && point.bad_normal) |->
		(point.point_x == 0 && point.point_y == 0 && point.point_z == 0))
		else $error("bad normal beat with nonzero point");

	a_weight: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (point.weight == (point.point_index[0] ? ncc_pkg::WEIGHT_DIAG
		: ncc_pkg::WEIGHT_ONE))) else $error("weight does not match point index");

endmodule

@@ hw/rtl/ncc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_front
// Input beat buffer and frame sequencer: normalises the normal, picks the
// helper axis, normalises u and forms v with one shared multiplier, a
// bit-serial square root and three divider lanes.
// ----------------------------------------------------------------------------
module ncc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  ncc_pkg::item_t   item,
	output logic             fq_push,
	output ncc_pkg::frame_t  fq_din,
	input  logic             fq_full
);

	ncc_pkg::front_st_t st_q, st_d;
	ncc_pkg::item_t     buf_q;
	logic               buf_vld_q;
	logic               take;

	ncc_pkg::frame_t    frm_q;
	logic [2:0][31:0]   mag_q;
	logic [2:0]         neg_q;
	logic [2:0][31:0]   n_q;
	logic               pass_q, zero_q;
	logic [4:0]         cnt_q;
	logic [1:0]         idx_q;
	logic [63:0]        acc_q, x_q, r_q, b_q;
	logic [2:0][31:0]   rem_q, dq_q;

	logic               all_zero, top_clear;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod;
	logic [63:0]        rb, x_n, r_n;
	logic               sq_ge;
	logic [2:0][31:0]   rem_n, dq_n, res;
	logic [2:0][32:0]   tdiv;
	logic signed [63:0] dsub;
	logic signed [63:0] dsub_r;

	assign full   = buf_vld_q;
	assign fq_din = frm_q;

	always_comb begin
		all_zero  = (mag_q[0] == '0) && (mag_q[1] == '0) && (mag_q[2] == '0);
		top_clear = (mag_q[0][31:30] == 2'b00) && (mag_q[1][31:30] == 2'b00)
			&& (mag_q[2][31:30] == 2'b00);
		if (st_q == ncc_pkg::F_CROSS) begin
			mul_a = {n_q[ncc_pkg::cross_n_idx(cnt_q[2:0])][31],
				n_q[ncc_pkg::cross_n_idx(cnt_q[2:0])]};
			mul_b = {frm_q.u[ncc_pkg::cross_u_idx(cnt_q[2:0])][31],
				frm_q.u[ncc_pkg::cross_u_idx(cnt_q[2:0])]};
		end else begin
			mul_a = {1'b0, mag_q[idx_q]};
			mul_b = {1'b0, mag_q[idx_q]};
		end
		prod   = mul_a * mul_b;
		rb     = r_q + b_q;
		sq_ge  = x_q >= rb;
		x_n    = sq_ge ? x_q - rb : x_q;
		r_n    = sq_ge ? (r_q >> 1) + b_q : r_q >> 1;
		for (int i = 0; i < 3; i++) begin
			tdiv[i]  = {rem_q[i], dq_q[i][31]};
			rem_n[i] = (tdiv[i] >= {1'b0, r_q[31:0]}) ? 32'(tdiv[i] - {1'b0, r_q[31:0]})
				: tdiv[i][31:0];
			dq_n[i]  = {dq_q[i][30:0], tdiv[i] >= {1'b0, r_q[31:0]}};
			res[i]   = zero_q ? '0 : (neg_q[i] ? 32'(-dq_q[i]) : dq_q[i]);
		end
		dsub   = $signed(acc_q) - $signed(prod[63:0]);
		dsub_r = dsub + 64'sd536870912;
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ncc_pkg::F_IDLE:  if (buf_vld_q) st_d = ncc_pkg::F_SHIFT;
			ncc_pkg::F_SHIFT: begin
				if (all_zero) st_d = ncc_pkg::F_NEXT;
				else if (!top_clear) st_d = ncc_pkg::F_SQ;
			end
			ncc_pkg::F_SQ:    if (idx_q == 2'd2) st_d = ncc_pkg::F_SQRT;
			ncc_pkg::F_SQRT:  if (cnt_q == 5'd31) st_d = ncc_pkg::F_DIV;
			ncc_pkg::F_DIV:   if (cnt_q == 5'd31) st_d = ncc_pkg::F_NEXT;
			ncc_pkg::F_NEXT: begin
				if (pass_q) st_d = ncc_pkg::F_CROSS;
				else if (zero_q) st_d = ncc_pkg::F_PUSH;
				else st_d = ncc_pkg::F_SHIFT;
			end
			ncc_pkg::F_CROSS: if (cnt_q == 5'd5) st_d = ncc_pkg::F_PUSH;
			ncc_pkg::F_PUSH:  if (!fq_full) st_d = ncc_pkg::F_IDLE;
			default:          st_d = ncc_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		take    = (st_q == ncc_pkg::F_IDLE) && buf_vld_q;
		fq_push = (st_q == ncc_pkg::F_PUSH) && !fq_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ncc_pkg::F_IDLE;
			buf_vld_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (push && !buf_vld_q) buf_vld_q <= 1'b1;
			else if (take) buf_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !buf_vld_q) buf_q <= item;
		unique case (st_q)
			ncc_pkg::F_IDLE: begin
				frm_q.ctr <= {buf_q.center_z, buf_q.center_y, buf_q.center_x};
				frm_q.rad <= buf_q.radius;
				frm_q.bad <= 1'b0;
				mag_q[0]  <= buf_q.normal_x[31] ? 32'(-buf_q.normal_x) : buf_q.normal_x;
				mag_q[1]  <= buf_q.normal_y[31] ? 32'(-buf_q.normal_y) : buf_q.normal_y;
				mag_q[2]  <= buf_q.normal_z[31] ? 32'(-buf_q.normal_z) : buf_q.normal_z;
				neg_q     <= {buf_q.normal_z[31], buf_q.normal_y[31], buf_q.normal_x[31]};
				pass_q    <= 1'b0;
				zero_q    <= 1'b0;
			end
			ncc_pkg::F_SHIFT: begin
				if (all_zero) begin
					zero_q <= 1'b1;
				end else if (top_clear) begin
					for (int i = 0; i < 3; i++) mag_q[i] <= {mag_q[i][30:0], 1'b0};
				end else begin
					idx_q <= 2'd0;
					acc_q <= '0;
				end
			end
			ncc_pkg::F_SQ: begin
				acc_q <= acc_q + prod[63:0];
				idx_q <= idx_q + 2'd1;
				if (idx_q == 2'd2) begin
					x_q   <= acc_q + prod[63:0];
					r_q   <= '0;
					b_q   <= 64'h4000_0000_0000_0000;
					cnt_q <= '0;
				end
			end
			ncc_pkg::F_SQRT: begin
				x_q   <= x_n;
				r_q   <= r_n;
				b_q   <= b_q >> 2;
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					for (int i = 0; i < 3; i++) begin
						rem_q[i] <= {2'b00, mag_q[i][31:2]};
						dq_q[i]  <= {mag_q[i][1:0], 30'd0};
					end
				end
			end
			ncc_pkg::F_DIV: begin
				rem_q <= rem_n;
				dq_q  <= dq_n;
				cnt_q <= cnt_q + 5'd1;
			end
			ncc_pkg::F_NEXT: begin
				if (pass_q) begin
					frm_q.u <= res;
					cnt_q   <= '0;
				end else if (zero_q) begin
					frm_q.bad <= 1'b1;
					frm_q.u   <= '0;
					frm_q.v   <= '0;
				end else begin
					n_q    <= res;
					pass_q <= 1'b1;
					if (dq_q[0] < ncc_pkg::HELPER_LIMIT) begin
						mag_q <= {dq_q[1], dq_q[2], 32'd0};
						neg_q <= {!neg_q[1], neg_q[2], 1'b0};
					end else begin
						mag_q <= {dq_q[0], 32'd0, dq_q[2]};
						neg_q <= {neg_q[0], 1'b0, !neg_q[2]};
					end
				end
			end
			ncc_pkg::F_CROSS: begin
				if (!cnt_q[0]) acc_q <= prod[63:0];
				else frm_q.v[cnt_q[2:1]] <= dsub_r[62:30];
				cnt_q <= cnt_q + 5'd1;
			end
			ncc_pkg::F_PUSH: ;
			default: ;
		endcase
	end

endmodule

@@ hw/rtl/ncc_frame_q.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_frame_q
// Two-entry queue of circle frames between the sequencer and point pipeline.
// ----------------------------------------------------------------------------
module ncc_frame_q (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  ncc_pkg::frame_t din,
	output logic            full,
	input  logic            rd,
	output ncc_pkg::frame_t dout,
	output logic            vld
);

	ncc_pkg::frame_t mem_q [2];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;

	assign full = cnt_q == 2'd2;
	assign vld  = cnt_q != 2'd0;
	assign dout = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= din;
	end

endmodule

@@ hw/rtl/ncc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_back
// Point pipeline: walks the nine corners of a frame, scales by the radius,
// adds the centre with saturation and queues the result beats.
// ----------------------------------------------------------------------------
module ncc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  ncc_pkg::frame_t frm,
	input  logic            frm_vld,
	output logic            frm_pop,
	output ncc_pkg::point_t point,
	output logic            empty,
	input  logic            pop
);

	logic [3:0]              k_q, k_s1, k_s2;
	logic                    vld_s1, vld_s2, bad_s1, bad_s2;
	logic [2:0][33:0]        d_s1;
	logic [2:0][31:0]        ctr_s1, ctr_s2;
	logic [30:0]             rad_s1;
	logic [2:0][65:0]        prod_s2;
	ncc_pkg::point_t         mem_q [4];
	logic [1:0]              wp_q, rp_q;
	logic [2:0]              cnt_q;
	logic                    issue, rd;
	logic [3:0]              used;
	logic signed [1:0]       px, py;
	logic [2:0][33:0]        d_n;
	logic [2:0][31:0]        pt;
	logic signed [65:0]      rnd;
	logic signed [36:0]      sum;
	ncc_pkg::point_t         wdat;

	assign used    = 4'(cnt_q) + 4'(vld_s1) + 4'(vld_s2);
	assign issue   = frm_vld && (used < ncc_pkg::PT_DEPTH);
	assign frm_pop = issue && (k_q == ncc_pkg::LAST_POINT);
	assign empty   = cnt_q == 3'd0;
	assign rd      = pop && !empty;
	assign point   = mem_q[rp_q];

	always_comb begin
		px = ncc_pkg::corner_px(k_q);
		py = ncc_pkg::corner_py(k_q);
		for (int i = 0; i < 3; i++) begin
			d_n[i] = 34'(px * $signed({frm.u[i][31], frm.u[i][31], frm.u[i]}))
				+ 34'(py * $signed({frm.v[i][32], frm.v[i]}));
		end
		for (int i = 0; i < 3; i++) begin
			rnd = $signed(prod_s2[i]) + 66'sd536870912;
			sum = 37'($signed(ctr_s2[i])) + 37'($signed(rnd[65:30]));
			if (bad_s2) pt[i] = '0;
			else if (sum > 37'sd2147483647) pt[i] = 32'h7FFF_FFFF;
			else if (sum < -37'sd2147483648) pt[i] = 32'h8000_0000;
			else pt[i] = sum[31:0];
		end
		wdat.point_index = k_s2;
		wdat.point_x     = pt[0];
		wdat.point_y     = pt[1];
		wdat.point_z     = pt[2];
		wdat.weight      = k_s2[0] ? ncc_pkg::WEIGHT_DIAG : ncc_pkg::WEIGHT_ONE;
		wdat.bad_normal  = bad_s2;
		wdat.last        = k_s2 == ncc_pkg::LAST_POINT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			wp_q   <= '0;
			rp_q   <= '0;
			cnt_q  <= '0;
		end else begin
			if (issue) k_q <= (k_q == ncc_pkg::LAST_POINT) ? 4'd0 : k_q + 4'd1;
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			if (vld_s2) wp_q <= wp_q + 2'd1;
			if (rd) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(vld_s2) - 3'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			d_s1   <= d_n;
			ctr_s1 <= frm.ctr;
			rad_s1 <= frm.rad;
			bad_s1 <= frm.bad;
			k_s1   <= k_q;
		end
		if (vld_s1) begin
			for (int i = 0; i < 3; i++)
				prod_s2[i] <= $signed({1'b0, rad_s1}) * $signed(d_s1[i]);
			ctr_s2 <= ctr_s1;
			bad_s2 <= bad_s1;
			k_s2   <= k_s1;
		end
		if (vld_s2) mem_q[wp_q] <= wdat;
	end

endmodule

@@ tb/nurbs_circle_control_points_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nurbs_circle_control_points_checker
// Watches the item and point queues, predicts the nine control points of
// every accepted circle and compares each popped point field by field.
// ----------------------------------------------------------------------------
module nurbs_circle_control_points_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic            full,
	input  ncc_pkg::item_t  item,
	input  logic            empty,
	input  logic            pop,
	input  ncc_pkg::point_t point,
	output int              errors,
	output int              pending
);
	import ncc_pkg::*;

	point_t points_due[$];

	assign pending = points_due.size();

	function automatic logic [63:0] sqrt_floor(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else
				r = r >> 1;
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint round_q30(input longint x);
		longint y;
		y = x + (64'sd1 <<< 29);
		return y >>> 30;
	endfunction

	function automatic bit unit_vec(input longint c[3], output longint o[3]);
		logic [63:0] mag[3];
		logic [63:0] m;
		logic [63:0] l2;
		logic [63:0] len;
		longint q;
		int s;
		m = 0;
		l2 = 0;
		s = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = (c[i] < 0) ? -c[i] : c[i];
			if (mag[i] > m)
				m = mag[i];
		end
		if (m == 0) begin
			for (int i = 0; i < 3; i++)
				o[i] = 0;
			return 0;
		end
		while (m < (64'd1 << 30)) begin
			m = m << 1;
			s++;
		end
		for (int i = 0; i < 3; i++) begin
			mag[i] = mag[i] << s;
			l2 = l2 + mag[i] * mag[i];
		end
		len = sqrt_floor(l2);
		for (int i = 0; i < 3; i++) begin
			q = (mag[i] << 30) / len;
			o[i] = (c[i] < 0) ? -q : q;
		end
		return 1;
	endfunction

	task automatic predict_circle(input item_t it);
		longint ctr[3], nrm[3], n[3], w[3], u[3], v[3];
		longint rad, d, p, ax;
		bit ok;
		point_t pt;
		ctr[0] = it.center_x;
		ctr[1] = it.center_y;
		ctr[2] = it.center_z;
		nrm[0] = it.normal_x;
		nrm[1] = it.normal_y;
		nrm[2] = it.normal_z;
		rad = {33'd0, it.radius};
		ok = unit_vec(nrm, n);
		if (ok) begin
			ax = (n[0] < 0) ? -n[0] : n[0];
			if (ax < longint'(HELPER_LIMIT)) begin
				w[0] = 0; w[1] = n[2]; w[2] = -n[1];
			end else begin
				w[0] = -n[2]; w[1] = 0; w[2] = n[0];
			end
			void'(unit_vec(w, u));
			v[0] = round_q30(n[1] * u[2] - n[2] * u[1]);
			v[1] = round_q30(n[2] * u[0] - n[0] * u[2]);
			v[2] = round_q30(n[0] * u[1] - n[1] * u[0]);
		end else
			for (int i = 0; i < 3; i++) begin
				u[i] = 0;
				v[i] = 0;
			end
		for (int k = 0; k < 9; k++) begin
			longint c3[3];
			for (int i = 0; i < 3; i++) begin
				p = 0;
				if (ok) begin
					d = longint'(corner_px(4'(k))) * u[i] + longint'(corner_py(4'(k))) * v[i];
					p = ctr[i] + round_q30(rad * d);
					if (p > 64'sd2147483647)
						p = 64'sd2147483647;
					if (p < -64'sd2147483648)
						p = -64'sd2147483648;
				end
				c3[i] = p;
			end
			pt.point_index = 4'(k);
			pt.point_x = c3[0][31:0];
			pt.point_y = c3[1][31:0];
			pt.point_z = c3[2][31:0];
			pt.weight = (k % 2 == 0) ? WEIGHT_ONE : WEIGHT_DIAG;
			pt.bad_normal = !ok;
			pt.last = (4'(k) == LAST_POINT);
			points_due.push_back(pt);
		end
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		point_t want;
		if (!arst_n)
			errors = 0;
		else begin
			if (push && !full)
				predict_circle(item);
			if (pop && !empty) begin
				if (points_due.size() == 0)
					report("unexpected beat", 32'(point.point_index), 32'd0);
				else begin
					want = points_due.pop_front();
					if (point.point_index !== want.point_index)
						report("point_index", 32'(point.point_index), 32'(want.point_index));
					if (point.point_x !== want.point_x)
						report("point_x", point.point_x, want.point_x);
					if (point.point_y !== want.point_y)
						report("point_y", point.point_y, want.point_y);
					if (point.point_z !== want.point_z)
						report("point_z", point.point_z, want.point_z);
					if (point.weight !== want.weight)
						report("weight", 32'(point.weight), 32'(want.weight));
					if (point.bad_normal !== want.bad_normal)
						report("bad_normal", 32'(point.bad_normal), 32'(want.bad_normal));
					if (point.last !== want.last)
						report("last", 32'(point.last), 32'(want.last));
				end
			end
		end
	end
endmodule

@@ tb/nurbs_circle_control_points_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nurbs_circle_control_points_test
// Drives directed and random circles into the block under random idling
// and gives the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module nurbs_circle_control_points_test;
	import ncc_pkg::*;

	logic   clk;
	logic   arst_n;
	logic   push;
	logic   full;
	item_t  item;
	logic   empty;
	logic   pop;
	point_t point;
	int     errors;
	int     pending;
	int     push_idle;
	int     pop_idle;

	nurbs_circle_control_points dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .point(point)
	);

	nurbs_circle_control_points_checker checker_i (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .point(point), .errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		#400ms;
		$display("tb: failure");
		$finish;
	end

	always @(posedge clk) begin
		if (!arst_n)
			pop <= 1'b0;
		else
			pop <= ($urandom_range(99) >= pop_idle);
	end

	function automatic logic [31:0] rand_word();
		logic [31:0] r;
		case ($urandom_range(5))
			0: r = 32'h7fffffff;
			1: r = 32'h80000000;
			2: r = $urandom_range(3) - 1;
			3: r = $signed($urandom_range(65535 * 8)) - 32'sd262144;
			default: r = $urandom;
		endcase
		return r;
	endfunction

	task automatic send(input item_t it);
		while ($urandom_range(99) < push_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic send_random();
		item_t it;
		it.center_x = rand_word();
		it.center_y = rand_word();
		it.center_z = rand_word();
		it.normal_x = rand_word();
		it.normal_y = rand_word();
		it.normal_z = rand_word();
		it.radius = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(32'h00ffffff));
		if ($urandom_range(49) == 0) begin
			it.normal_x = 0;
			it.normal_y = 0;
			it.normal_z = 0;
		end
		send(it);
	endtask

	initial begin
		item_t it;
		push = 1'b0;
		pop = 1'b0;
		item = '0;
		push_idle = 23;
		pop_idle = 64;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// axis-aligned normals, zero normal, extremes and the helper switch
		it = '{32'h10000, 32'h20000, -32'sh30000, 32'h10000, 0, 0, 31'h10000};
		send(it);
		it = '{0, 0, 0, 0, 32'h10000, 0, 31'h10000};
		send(it);
		it = '{0, 0, 0, 0, 0, -32'sh10000, 31'h20000};
		send(it);
		it = '{32'h1234, 32'h5678, 0, 0, 0, 0, 31'h10000};
		send(it);
		it = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 1, 1, 1, 31'h7fffffff};
		send(it);
		it = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 31'h7fffffff};
		send(it);
		it = '{0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 31'h0};
		send(it);
		it = '{0, 0, 0, 32'sd58982, 32'sd28562, 0, 31'h10000};
		send(it);
		it = '{0, 0, 0, 32'sd58983, 32'sd28561, 0, 31'h10000};
		send(it);
		it = '{0, 0, 0, 1, 0, 0, 31'h7fffffff};
		send(it);
		it = '{0, 0, 0, -32'sd1, 0, 0, 31'h40000000};
		send(it);
		for (int i = 0; i < 320; i++) begin
			if (i == 110) begin
				push_idle = 64;
				pop_idle = 23;
			end else if (i == 220) begin
				push_idle = 0;
				pop_idle = 0;
			end
			send_random();
		end
		push <= 1'b0;
		fork
			begin
				while (pending != 0)
					@(posedge clk);
				repeat (300) @(posedge clk);
			end
			begin
				repeat (200000) @(posedge clk);
			end
		join_any
		if (errors == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
